### rtl/dynamic_window_velocity_planner_top_defines.svh
// Assertion macros for the planner RTL.
// Included by dwvp_back, which checks its own sequencing; no other dependencies.
`ifndef DYNAMIC_WINDOW_VELOCITY_PLANNER_TOP_DEFINES_SVH
`define DYNAMIC_WINDOW_VELOCITY_PLANNER_TOP_DEFINES_SVH
`ifndef SYNTH
`define DWVP_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwvp assertion failed");
`define DWVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwvp assertion failed");
`else
`define DWVP_ASSERT(lbl, clk, rst_n, ante, cons)
`define DWVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dwvp_pkg.sv
// Shared types, constants and angle helpers for the velocity planner.
// No dependencies; imported by every planner module.
package dwvp_pkg;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RESOLUTION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RESOLUTION  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_RATIO    = 3'd7;

    localparam logic signed [19:0] Q_PI        = 20'sd205887;
    localparam logic signed [19:0] Q_HALF_PI   = 20'sd102944;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [23:0] PI_24       = 24'sd205887;
    localparam logic signed [23:0] TWO_PI_24   = 24'sd411775;
    localparam logic [32:0]        Q_RADIUS    = 33'd13107;
    localparam logic [30:0]        Q_RADIUS_SQ = 31'd171793449;
    localparam logic [5:0]         SWEEP_LAST  = 6'd63;

    typedef struct packed {
        logic               op;
        logic [7:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [8:0]         path_length;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [19:0] robot_heading;
        logic signed [19:0] robot_speed;
        logic signed [19:0] robot_turn_rate;
    } t_item;

    typedef struct packed {
        logic signed [19:0] min_speed;
        logic signed [19:0] max_speed;
        logic [18:0]        speed_step_limit;
        logic [18:0]        max_turn_rate;
        logic [18:0]        turn_step_limit;
        logic [18:0]        speed_resolution;
        logic [18:0]        turn_resolution;
        logic [15:0]        heading_weight_ratio;
    } t_cfg;

    function automatic logic [15:0] atan_q(input logic [3:0] i);
        case (i)
            4'd0:    return 16'd51472;
            4'd1:    return 16'd30386;
            4'd2:    return 16'd16055;
            4'd3:    return 16'd8150;
            4'd4:    return 16'd4091;
            4'd5:    return 16'd2047;
            4'd6:    return 16'd1024;
            4'd7:    return 16'd512;
            4'd8:    return 16'd256;
            4'd9:    return 16'd128;
            4'd10:   return 16'd64;
            4'd11:   return 16'd32;
            4'd12:   return 16'd16;
            4'd13:   return 16'd8;
            4'd14:   return 16'd4;
            default: return 16'd2;
        endcase
    endfunction

    // single correction: valid for |e| below three half turns
    function automatic logic signed [19:0] wrap_angle(input logic signed [23:0] e);
        logic signed [23:0] r;
        r = e;
        if (e > PI_24) begin
            r = e - TWO_PI_24;
        end else if (e < -PI_24) begin
            r = e + TWO_PI_24;
        end
        return r[19:0];
    endfunction

endpackage

### rtl/dwvp_front.sv
// Front end: accepts input words, drops out-of-range waypoint writes,
// clamps path length and queues items for the back end. Uses dwvp_pkg.
module dwvp_front #(
    parameter int PATH_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [7:0]          i_point_index,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic [8:0]          i_path_length,
    input  logic signed [31:0]  i_robot_x,
    input  logic signed [31:0]  i_robot_y,
    input  logic signed [19:0]  i_robot_heading,
    input  logic signed [19:0]  i_robot_speed,
    input  logic signed [19:0]  i_robot_turn_rate,
    output logic                o_q_valid,
    output dwvp_pkg::t_item     o_q_item,
    input  logic                i_q_pop
);
    import dwvp_pkg::*;

    localparam int QD = 2;
    localparam int QW = $clog2(QD);

    t_item          r_q [QD];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [QW:0]    r_count;
    t_item          n_item;
    logic           keep;
    logic           push;

    always_comb begin
        n_item.op              = i_operation;
        n_item.point_index     = i_point_index;
        n_item.point_x         = i_point_x;
        n_item.point_y         = i_point_y;
        n_item.path_length     = i_path_length;
        n_item.robot_x         = i_robot_x;
        n_item.robot_y         = i_robot_y;
        n_item.robot_heading   = i_robot_heading;
        n_item.robot_speed     = i_robot_speed;
        n_item.robot_turn_rate = i_robot_turn_rate;
        if (32'(i_path_length) > PATH_DEPTH) begin
            n_item.path_length = 9'(PATH_DEPTH);
        end
    end

    assign keep      = (i_operation == OP_REQUEST) || (32'(i_point_index) < PATH_DEPTH);
    assign o_stall   = (r_count == (QW+1)'(QD));
    assign push      = i_valid && !o_stall && keep;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/dwvp_back.sv
// Back end: waypoint store, target check, window sweep, CORDIC rollout
// and scoring. Uses dwvp_pkg and the assertion macro header.
module dwvp_back #(
    parameter int PATH_DEPTH    = 256,
    parameter int PREDICT_STEPS = 31,
    parameter int STEP_TIME_Q16 = 6554
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dwvp_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  dwvp_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic signed [19:0]  o_cmd_speed,
    output logic signed [19:0]  o_cmd_turn_rate,
    output logic [8:0]          o_target_slot,
    output logic                o_path_done
);
    import dwvp_pkg::*;
    `include "dynamic_window_velocity_planner_top_defines.svh"

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int KW = $clog2(PREDICT_STEPS + 1);
    localparam logic signed [17:0] STEP_Q = 18'(STEP_TIME_Q16);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_CHK, S_RD_B, S_WIN, S_CAND, S_STEP_A, S_STEP_B,
        S_ROT, S_STEP_C, S_STEP_D, S_VEC_INIT, S_VEC, S_SCORE_A, S_SCORE_B, S_FINISH
    } t_state;

    t_state             r_state;
    logic [31:0]        r_mem_x [PATH_DEPTH];
    logic [31:0]        r_mem_y [PATH_DEPTH];
    logic [31:0]        r_rd_x, r_rd_y;
    logic [8:0]         r_target, r_len;
    logic signed [31:0] r_rx, r_ry, r_tx, r_ty;
    logic signed [19:0] r_th, r_sp, r_tr;
    logic signed [21:0] r_vhi, r_wlo, r_whi, r_v, r_w;
    logic [18:0]        r_vres, r_wres;
    logic [5:0]         r_nv, r_nw;
    logic signed [19:0] r_dth, r_ptw, r_thw;
    logic signed [33:0] r_px, r_py;
    logic [KW-1:0]      r_k;
    logic signed [19:0] r_cx, r_cy, r_cz;
    logic               r_neg;
    logic [3:0]         r_iter;
    logic signed [23:0] r_m1x, r_m1y;
    logic signed [37:0] r_vx, r_vy;
    logic signed [19:0] r_vz;
    logic [17:0]        r_err;
    logic [35:0]        r_best_cost;
    logic               r_have, r_done;
    logic signed [19:0] r_best_v, r_best_w;
    logic               r_out_valid;
    logic signed [19:0] r_out_speed, r_out_turn;
    logic [8:0]         r_out_slot;
    logic               r_out_done;

    logic               mem_we;
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic [30:0]        ax31, ay31, dist_sq;
    logic               near;
    logic [8:0]         t_inc;
    logic signed [21:0] sp22, tr22, min22, max22, ssl22, tsl22, mtr22;
    logic signed [21:0] vlo_c, vhi_c, wlo_c, whi_c;
    logic signed [37:0] dth_prod, dth_rnd;
    logic signed [19:0] c_val, s_val, at20;
    logic signed [39:0] m1x_prod, m1y_prod, m1x_rnd, m1y_rnd;
    logic signed [41:0] m2x_prod, m2y_prod, m2x_rnd, m2y_rnd;
    logic signed [37:0] ex, ey, vsx, vsy;
    logic signed [19:0] rsx, rsy, e20, e_abs;
    logic [33:0]        hterm;
    logic signed [21:0] vshort;
    logic [35:0]        cost;
    logic signed [21:0] v_nx, w_nx;
    logic               w_more, v_more, out_free;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign mem_we  = o_q_pop && (i_q_item.op == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[AW'(i_q_item.point_index)] <= i_q_item.point_x;
            r_mem_y[AW'(i_q_item.point_index)] <= i_q_item.point_y;
        end
        r_rd_x <= r_mem_x[AW'(r_target)];
        r_rd_y <= r_mem_y[AW'(r_target)];
    end

    always_comb begin
        dx      = $signed({r_rd_x[31], r_rd_x}) - $signed({r_rx[31], r_rx});
        dy      = $signed({r_rd_y[31], r_rd_y}) - $signed({r_ry[31], r_ry});
        adx     = dx[32] ? 33'(-dx) : 33'(dx);
        ady     = dy[32] ? 33'(-dy) : 33'(dy);
        ax31    = 31'(adx[14:0]);
        ay31    = 31'(ady[14:0]);
        dist_sq = ax31 * ax31 + ay31 * ay31;
        near    = (adx < Q_RADIUS) && (ady < Q_RADIUS) && (dist_sq < Q_RADIUS_SQ);
        t_inc   = r_target + 9'd1;

        sp22  = 22'(r_sp);
        tr22  = 22'(r_tr);
        min22 = 22'($signed(i_cfg.min_speed));
        max22 = 22'($signed(i_cfg.max_speed));
        ssl22 = $signed({3'b0, i_cfg.speed_step_limit});
        tsl22 = $signed({3'b0, i_cfg.turn_step_limit});
        mtr22 = $signed({3'b0, i_cfg.max_turn_rate});
        vlo_c = sp22 - ssl22;
        if (vlo_c < min22) begin
            vlo_c = min22;
        end
        vhi_c = sp22 + ssl22;
        if (vhi_c > max22) begin
            vhi_c = max22;
        end
        wlo_c = tr22 - tsl22;
        if (wlo_c < -mtr22) begin
            wlo_c = -mtr22;
        end
        whi_c = tr22 + tsl22;
        if (whi_c > mtr22) begin
            whi_c = mtr22;
        end

        dth_prod = $signed(r_w[19:0]) * STEP_Q;
        dth_rnd  = (dth_prod + 38'sd32768) >>> 16;

        c_val    = r_neg ? -r_cx : r_cx;
        s_val    = r_neg ? -r_cy : r_cy;
        m1x_prod = $signed(r_v[19:0]) * c_val;
        m1y_prod = $signed(r_v[19:0]) * s_val;
        m1x_rnd  = (m1x_prod + 40'sd32768) >>> 16;
        m1y_rnd  = (m1y_prod + 40'sd32768) >>> 16;
        m2x_prod = r_m1x * STEP_Q;
        m2y_prod = r_m1y * STEP_Q;
        m2x_rnd  = (m2x_prod + 42'sd32768) >>> 16;
        m2y_rnd  = (m2y_prod + 42'sd32768) >>> 16;

        at20 = $signed({4'b0, atan_q(r_iter)});
        rsx  = r_cx >>> r_iter;
        rsy  = r_cy >>> r_iter;
        ex   = 38'(r_tx) - 38'(r_px);
        ey   = 38'(r_ty) - 38'(r_py);
        vsx  = r_vx >>> r_iter;
        vsy  = r_vy >>> r_iter;

        e20    = wrap_angle(24'(r_vz) - 24'(r_ptw));
        e_abs  = (e20 < 0) ? -e20 : e20;
        hterm  = 34'(i_cfg.heading_weight_ratio) * 34'(r_err);
        vshort = max22 - r_v;
        cost   = 36'(hterm) + {6'b0, vshort, 8'b0};

        v_nx   = r_v + $signed({3'b0, r_vres});
        w_nx   = r_w + $signed({3'b0, r_wres});
        w_more = (r_nw != SWEEP_LAST) && (w_nx <= r_whi);
        v_more = (r_nv != SWEEP_LAST) && (v_nx <= r_vhi);
        out_free = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_FINISH owns the output valid while it is waiting to load
            if ((r_state != S_FINISH) && r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && (i_q_item.op == OP_REQUEST)) begin
                        r_len    <= i_q_item.path_length;
                        r_rx     <= i_q_item.robot_x;
                        r_ry     <= i_q_item.robot_y;
                        r_th     <= i_q_item.robot_heading;
                        r_sp     <= i_q_item.robot_speed;
                        r_tr     <= i_q_item.robot_turn_rate;
                        r_have   <= 1'b0;
                        r_done   <= 1'b0;
                        r_best_v <= '0;
                        r_best_w <= '0;
                        r_state  <= S_RD_A;
                    end
                end
                S_RD_A: r_state <= S_CHK;
                S_CHK: begin
                    if (r_target >= r_len) begin
                        r_done  <= 1'b1;
                        r_state <= S_FINISH;
                    end else if (near) begin
                        r_target <= t_inc;
                        if (t_inc >= r_len) begin
                            r_done  <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_RD_B;
                        end
                    end else begin
                        r_state <= S_RD_B;
                    end
                end
                S_RD_B: r_state <= S_WIN;
                S_WIN: begin
                    r_tx   <= r_rd_x;
                    r_ty   <= r_rd_y;
                    r_thw  <= wrap_angle(24'(r_th));
                    r_vhi  <= vhi_c;
                    r_wlo  <= wlo_c;
                    r_whi  <= whi_c;
                    r_v    <= vlo_c;
                    r_w    <= wlo_c;
                    r_nv   <= '0;
                    r_nw   <= '0;
                    r_vres <= (i_cfg.speed_resolution == '0) ? 19'd1 : i_cfg.speed_resolution;
                    r_wres <= (i_cfg.turn_resolution == '0) ? 19'd1 : i_cfg.turn_resolution;
                    if ((vlo_c > vhi_c) || (wlo_c > whi_c)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_dth   <= wrap_angle(dth_rnd[23:0]);
                    r_ptw   <= r_thw;
                    r_px    <= 34'(r_rx);
                    r_py    <= 34'(r_ry);
                    r_k     <= '0;
                    r_state <= S_STEP_A;
                end
                S_STEP_A: begin
                    r_ptw   <= wrap_angle(24'(r_ptw) + 24'(r_dth));
                    r_state <= S_STEP_B;
                end
                S_STEP_B: begin
                    // fold into the right half plane, negate the result later
                    if (r_ptw > Q_HALF_PI) begin
                        r_cz  <= r_ptw - Q_PI;
                        r_neg <= 1'b1;
                    end else if (r_ptw < -Q_HALF_PI) begin
                        r_cz  <= r_ptw + Q_PI;
                        r_neg <= 1'b1;
                    end else begin
                        r_cz  <= r_ptw;
                        r_neg <= 1'b0;
                    end
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= '0;
                    r_iter  <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - rsy;
                        r_cy <= r_cy + rsx;
                        r_cz <= r_cz - at20;
                    end else begin
                        r_cx <= r_cx + rsy;
                        r_cy <= r_cy - rsx;
                        r_cz <= r_cz + at20;
                    end
                    r_iter <= r_iter + 4'd1;
                    if (r_iter == 4'd15) begin
                        r_state <= S_STEP_C;
                    end
                end
                S_STEP_C: begin
                    r_m1x   <= m1x_rnd[23:0];
                    r_m1y   <= m1y_rnd[23:0];
                    r_state <= S_STEP_D;
                end
                S_STEP_D: begin
                    r_px <= r_px + 34'(m2x_rnd);
                    r_py <= r_py + 34'(m2y_rnd);
                    r_k  <= r_k + 1'b1;
                    if (r_k == KW'(PREDICT_STEPS - 1)) begin
                        r_state <= S_VEC_INIT;
                    end else begin
                        r_state <= S_STEP_A;
                    end
                end
                S_VEC_INIT: begin
                    r_iter <= '0;
                    if ((ex == 0) && (ey == 0)) begin
                        r_vz    <= '0;
                        r_state <= S_SCORE_A;
                    end else if (ex < 0) begin
                        r_vz    <= (ey >= 0) ? Q_PI : -Q_PI;
                        r_vx    <= -ex;
                        r_vy    <= -ey;
                        r_state <= S_VEC;
                    end else begin
                        r_vz    <= '0;
                        r_vx    <= ex;
                        r_vy    <= ey;
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (r_vy > 0) begin
                        r_vx <= r_vx + vsy;
                        r_vy <= r_vy - vsx;
                        r_vz <= r_vz + at20;
                    end else begin
                        r_vx <= r_vx - vsy;
                        r_vy <= r_vy + vsx;
                        r_vz <= r_vz - at20;
                    end
                    r_iter <= r_iter + 4'd1;
                    if (r_iter == 4'd15) begin
                        r_state <= S_SCORE_A;
                    end
                end
                S_SCORE_A: begin
                    r_err   <= e_abs[17:0];
                    r_state <= S_SCORE_B;
                end
                S_SCORE_B: begin
                    // strict compare keeps the first candidate on a tie
                    if (!r_have || (cost < r_best_cost)) begin
                        r_have      <= 1'b1;
                        r_best_cost <= cost;
                        r_best_v    <= r_v[19:0];
                        r_best_w    <= r_w[19:0];
                    end
                    if (w_more) begin
                        r_w     <= w_nx;
                        r_nw    <= r_nw + 6'd1;
                        r_state <= S_CAND;
                    end else if (v_more) begin
                        r_v     <= v_nx;
                        r_nv    <= r_nv + 6'd1;
                        r_w     <= r_wlo;
                        r_nw    <= '0;
                        r_state <= S_CAND;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_speed <= r_done ? 20'sd0 : r_best_v;
                        r_out_turn  <= r_done ? 20'sd0 : r_best_w;
                        r_out_slot  <= r_target;
                        r_out_done  <= r_done;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cmd_speed     = r_out_speed;
    assign o_cmd_turn_rate = r_out_turn;
    assign o_target_slot   = r_out_slot;
    assign o_path_done     = r_out_done;

    `DWVP_ASSERT(a_halt_zero, i_clk, i_rst_n, r_out_valid && r_out_done, (r_out_speed == 20'sd0) && (r_out_turn == 20'sd0))
    `DWVP_ASSERT(a_target_mono, i_clk, i_rst_n, $past(i_rst_n), r_target >= $past(r_target))
    `DWVP_ASSERT(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_state == S_IDLE)
    `DWVP_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, (r_state == S_FINISH) && out_free, r_out_valid && (r_state == S_IDLE))

endmodule

### rtl/dynamic_window_velocity_planner_top.sv
// A write word waits in the front queue and is stored when the idle back end pops it;
// a halted request skips the sweep, otherwise the back end scores N candidates
// (at most 64 x 64), each rolled out with a 16-step CORDIC rotation per rollout step.
// Only one request is in work at a time, with two words queued ahead of it.
// Synchronous active-low reset clears control and target index, loads config defaults;
// the waypoint store is undefined until written.
module dynamic_window_velocity_planner_top #(
    parameter int PATH_DEPTH    = 256,
    parameter int PREDICT_STEPS = 31,
    parameter int STEP_TIME_Q16 = 6554
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [7:0]                          i_point_index,
    input  logic signed [31:0]                  i_point_x,
    input  logic signed [31:0]                  i_point_y,
    input  logic [8:0]                          i_path_length,
    input  logic signed [31:0]                  i_robot_x,
    input  logic signed [31:0]                  i_robot_y,
    input  logic signed [19:0]                  i_robot_heading,
    input  logic signed [19:0]                  i_robot_speed,
    input  logic signed [19:0]                  i_robot_turn_rate,
    input  logic                                i_cfg_wr_en,
    input  logic [dwvp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dwvp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [19:0]                  o_cmd_speed,
    output logic signed [19:0]                  o_cmd_turn_rate,
    output logic [8:0]                          o_target_slot,
    output logic                                o_path_done
);
    import dwvp_pkg::*;

    t_cfg  r_cfg;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_speed            <= 20'sd0;
            r_cfg.max_speed            <= 20'sd65536;
            r_cfg.speed_step_limit     <= 19'd3277;
            r_cfg.max_turn_rate        <= 19'd65536;
            r_cfg.turn_step_limit      <= 19'd6554;
            r_cfg.speed_resolution     <= 19'd655;
            r_cfg.turn_resolution      <= 19'd655;
            r_cfg.heading_weight_ratio <= 16'd256;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MIN_SPEED:        r_cfg.min_speed            <= i_cfg_data;
                CFG_MAX_SPEED:        r_cfg.max_speed            <= i_cfg_data;
                CFG_SPEED_STEP_LIMIT: r_cfg.speed_step_limit     <= i_cfg_data[18:0];
                CFG_MAX_TURN_RATE:    r_cfg.max_turn_rate        <= i_cfg_data[18:0];
                CFG_TURN_STEP_LIMIT:  r_cfg.turn_step_limit      <= i_cfg_data[18:0];
                CFG_SPEED_RESOLUTION: r_cfg.speed_resolution     <= i_cfg_data[18:0];
                CFG_TURN_RESOLUTION:  r_cfg.turn_resolution      <= i_cfg_data[18:0];
                CFG_HEADING_RATIO:    r_cfg.heading_weight_ratio <= i_cfg_data[15:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    dwvp_front #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_point_index     (i_point_index),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .i_path_length     (i_path_length),
        .i_robot_x         (i_robot_x),
        .i_robot_y         (i_robot_y),
        .i_robot_heading   (i_robot_heading),
        .i_robot_speed     (i_robot_speed),
        .i_robot_turn_rate (i_robot_turn_rate),
        .o_q_valid         (q_valid),
        .o_q_item          (q_item),
        .i_q_pop           (q_pop)
    );

    dwvp_back #(
        .PATH_DEPTH    (PATH_DEPTH),
        .PREDICT_STEPS (PREDICT_STEPS),
        .STEP_TIME_Q16 (STEP_TIME_Q16)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_cmd_speed     (o_cmd_speed),
        .o_cmd_turn_rate (o_cmd_turn_rate),
        .o_target_slot   (o_target_slot),
        .o_path_done     (o_path_done)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for dynamic_window_velocity_planner_top.
// Depends on rtl/dwvp_pkg.sv for the config indexes, operation codes and t_item.
`timescale 1ns / 100ps

module testbench;
    import dwvp_pkg::*;

    localparam int     DEPTH     = 256;
    localparam int     STEPS     = 31;
    localparam longint DT        = 6554;
    localparam int     SWEEP_MAX = 64;
    localparam longint PI_Q      = 205887;
    localparam longint TWO_PI_Q  = 411775;
    localparam longint HALF_PI_Q = 102944;
    localparam longint RAD_Q     = 13107;
    localparam longint GAIN_Q    = 39797;

    typedef struct {
        logic signed [19:0] speed;
        logic signed [19:0] turn;
        logic [8:0]         slot;
        logic               done;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_operation = OP_WRITE;
    logic [7:0] i_point_index = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic [8:0] i_path_length = '0;
    logic signed [31:0] i_robot_x = '0;
    logic signed [31:0] i_robot_y = '0;
    logic signed [19:0] i_robot_heading = '0;
    logic signed [19:0] i_robot_speed = '0;
    logic signed [19:0] i_robot_turn_rate = '0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [19:0] o_cmd_speed;
    logic signed [19:0] o_cmd_turn_rate;
    logic [8:0] o_target_slot;
    logic o_path_done;

    dynamic_window_velocity_planner_top dut (.*);

    always #5 i_clk = ~i_clk;

    // planner state mirrored on the testbench side
    logic [31:0] wp_x [DEPTH];
    logic [31:0] wp_y [DEPTH];
    bit          wp_written [DEPTH];
    int          cur_slot = 0;
    longint c_min = 0, c_max = 65536, c_vstep = 3277, c_wmax = 65536;
    longint c_wstep = 6554, c_vres = 655, c_wres = 655, c_ratio = 256;
    longint atan_steps [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2};

    t_cmd cmd_q [$];
    int   errors = 0;
    bit   gaps_on = 1'b1;

    function automatic longint mul_q(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic longint wrap_q(longint e);
        if (e > PI_Q) e -= ((e - PI_Q + TWO_PI_Q - 1) / TWO_PI_Q) * TWO_PI_Q;
        if (e < -PI_Q) e += ((-PI_Q - e + TWO_PI_Q - 1) / TWO_PI_Q) * TWO_PI_Q;
        return e;
    endfunction

    task automatic rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, nx;
        bit flip;
        x = GAIN_Q; y = 0; flip = 0;
        z = wrap_q(ang);
        if (z > HALF_PI_Q) begin
            z -= PI_Q; flip = 1;
        end else if (z < -HALF_PI_Q) begin
            z += PI_Q; flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_steps[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_steps[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint bearing(longint y, longint x);
        longint z, nx;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x; y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_steps[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_steps[i];
            end
            x = nx;
        end
        return z;
    endfunction

    // target check, window sweep and rollout scoring for one request
    task automatic plan_command(input t_item it, output t_cmd r);
        longint len, rx, ry, tx, ty, dx, dy, vlo, vhi, wlo, whi, v, w, vres, wres;
        longint px, py, pt, c, s, err, cost, best_v, best_w, best_cost;
        bit have, done;
        int nv, nw;
        have = 0; done = 0; best_v = 0; best_w = 0; best_cost = 0;
        len = longint'(it.path_length);
        if (len > DEPTH) len = DEPTH;
        rx = longint'(it.robot_x); ry = longint'(it.robot_y);
        if (cur_slot >= len) begin
            done = 1;
        end else begin
            dx = longint'($signed(wp_x[cur_slot])) - rx;
            dy = longint'($signed(wp_y[cur_slot])) - ry;
            if (dx > -RAD_Q && dx < RAD_Q && dy > -RAD_Q && dy < RAD_Q
                && dx * dx + dy * dy < RAD_Q * RAD_Q) begin
                cur_slot++;
                if (cur_slot >= len) done = 1;
            end
        end
        if (!done) begin
            tx = longint'($signed(wp_x[cur_slot]));
            ty = longint'($signed(wp_y[cur_slot]));
            vlo = longint'(it.robot_speed) - c_vstep; if (vlo < c_min) vlo = c_min;
            vhi = longint'(it.robot_speed) + c_vstep; if (vhi > c_max) vhi = c_max;
            wlo = longint'(it.robot_turn_rate) - c_wstep; if (wlo < -c_wmax) wlo = -c_wmax;
            whi = longint'(it.robot_turn_rate) + c_wstep; if (whi > c_wmax) whi = c_wmax;
            vres = c_vres ? c_vres : 1;
            wres = c_wres ? c_wres : 1;
            v = vlo; nv = 0;
            while (v <= vhi && nv < SWEEP_MAX) begin
                w = wlo; nw = 0;
                while (w <= whi && nw < SWEEP_MAX) begin
                    px = rx; py = ry; pt = longint'(it.robot_heading);
                    for (int k = 0; k < STEPS; k++) begin
                        pt += mul_q(w, DT);
                        rotate(pt, c, s);
                        px += mul_q(mul_q(v, c), DT);
                        py += mul_q(mul_q(v, s), DT);
                    end
                    err = wrap_q(bearing(ty - py, tx - px) - pt);
                    if (err < 0) err = -err;
                    cost = c_ratio * err + (c_max - v) * 256;
                    if (!have || cost < best_cost) begin
                        have = 1; best_cost = cost; best_v = v; best_w = w;
                    end
                    w += wres; nw++;
                end
                v += vres; nv++;
            end
        end
        r.speed = done ? '0 : best_v[19:0];
        r.turn  = done ? '0 : best_w[19:0];
        r.slot  = cur_slot[8:0];
        r.done  = done;
    endtask

    // never let a request read a slot that has not been written
    function automatic void make_legal(ref t_item it);
        int eff;
        eff = (it.path_length > DEPTH) ? DEPTH : it.path_length;
        if ((cur_slot < eff && !wp_written[cur_slot])
            || (cur_slot + 1 < eff && !wp_written[cur_slot + 1]))
            it.path_length = cur_slot[8:0];
    endfunction

    task automatic send_word(input t_item it);
        t_cmd r;
        if (it.op == OP_REQUEST) make_legal(it);
        if (gaps_on && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= it.op;
        i_point_index <= it.point_index;
        i_point_x <= it.point_x;
        i_point_y <= it.point_y;
        i_path_length <= it.path_length;
        i_robot_x <= it.robot_x;
        i_robot_y <= it.robot_y;
        i_robot_heading <= it.robot_heading;
        i_robot_speed <= it.robot_speed;
        i_robot_turn_rate <= it.robot_turn_rate;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (it.op == OP_WRITE) begin
            wp_x[it.point_index] = it.point_x;
            wp_y[it.point_index] = it.point_y;
            wp_written[it.point_index] = 1'b1;
        end else begin
            plan_command(it, r);
            cmd_q.insert(cmd_q.size(), r);
        end
    endtask

    task automatic put_point(input int slot, input longint x, input longint y);
        t_item it;
        it = '0;
        it.op = OP_WRITE; it.point_index = slot[7:0];
        it.point_x = x[31:0]; it.point_y = y[31:0];
        send_word(it);
    endtask

    task automatic ask(input int len, input longint x, input longint y, input longint hd,
                       input longint sp, input longint tr);
        t_item it;
        it = '0;
        it.op = OP_REQUEST; it.path_length = len[8:0];
        it.robot_x = x[31:0]; it.robot_y = y[31:0];
        it.robot_heading = hd[19:0]; it.robot_speed = sp[19:0];
        it.robot_turn_rate = tr[19:0];
        send_word(it);
    endtask

    // drain outstanding words, then let trailing waypoint writes settle
    task automatic drain();
        i_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(input longint mn, input longint mx, input longint vs,
                              input longint wm, input longint ws, input longint vr,
                              input longint wr, input longint ra);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_IDX_W-1:0]  idx  [8];
        drain();
        vals = '{mn[19:0], mx[19:0], vs[19:0], wm[19:0], ws[19:0], vr[19:0], wr[19:0],
                 ra[19:0]};
        idx = '{CFG_MIN_SPEED, CFG_MAX_SPEED, CFG_SPEED_STEP_LIMIT, CFG_MAX_TURN_RATE,
                CFG_TURN_STEP_LIMIT, CFG_SPEED_RESOLUTION, CFG_TURN_RESOLUTION,
                CFG_HEADING_RATIO};
        for (int i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        c_min = longint'($signed(mn[19:0]));
        c_max = longint'($signed(mx[19:0]));
        c_vstep = longint'(vs[18:0]); c_wmax = longint'(wm[18:0]);
        c_wstep = longint'(ws[18:0]);
        c_vres = longint'(vr[18:0]); c_wres = longint'(wr[18:0]);
        c_ratio = longint'(ra[15:0]);
    endtask

    // reset config; robot on a waypoint whose successor sits on the same spot
    task automatic test_reset_defaults();
        put_point(0, 0, 0);
        put_point(1, 0, 0);
        put_point(2, 400000, -300000);
        ask(3, 0, 0, 0, 0, 0);
    endtask

    task automatic test_field_extremes();
        set_config(-524288, 524287, 524287, 524287, 524287, 524287, 524287, 65535);
        ask(3, -2147483648, 2147483647, 411775, -524288, 524287);
        ask(3, 2147483647, -2147483648, -411775, 524287, -524288);
        put_point(255, -2147483648, 2147483647);
        put_point(3, 2147483647, -2147483648);
        ask(511, 0, 0, 0, 0, 0);
        set_config(-65536, 131072, 30000, 90000, 30000, 30000, 30000, 0);
        ask(256, 12345, -54321, 200000, 1000, -1000);
        ask(0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_empty_window();
        set_config(100000, -100000, 1000, 65536, 1000, 500, 500, 256);
        ask(256, 0, 0, 0, 0, 0);
    endtask

    task automatic test_zero_resolution();
        set_config(-65536, 65536, 2, 65536, 2, 0, 0, 512);
        ask(256, -7000, 9000, -100000, 300, -300);
    endtask

    task automatic test_fine_sweep();
        set_config(-65536, 65536, 0, 65536, 100, 1, 1, 300);
        ask(256, 5000, 5000, 50000, 2000, 0);
    endtask

    task automatic test_past_end();
        ask(cur_slot, 0, 0, 0, 0, 0);
        ask(1, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_phase(input int n, input bit gaps);
        t_item it;
        int sent, k, base;
        longint bx, by;
        sent = 0;
        gaps_on = gaps;
        while (sent < n) begin
            k = $urandom_range(99);
            it.op = OP_WRITE;
            if (k < 15) begin
                it = '0;
                it.op = OP_WRITE;
                it.point_index = 8'($urandom); it.point_x = $urandom; it.point_y = $urandom;
                send_word(it); sent++;
            end else if (k < 25) begin
                it.op = OP_REQUEST;
                it.point_index = 8'($urandom); it.point_x = $urandom; it.point_y = $urandom;
                it.path_length = 9'($urandom);
                it.robot_x = $urandom; it.robot_y = $urandom;
                it.robot_heading = 20'($signed($urandom_range(0, 823550)) - 411775);
                it.robot_speed = 20'($urandom); it.robot_turn_rate = 20'($urandom);
                send_word(it); sent++;
            end else begin
                // waypoints ahead of the target, then requests close to it
                base = cur_slot;
                bx = $signed($urandom_range(0, 400000)) - 200000;
                by = $signed($urandom_range(0, 400000)) - 200000;
                for (int j = 0; j < $urandom_range(1, 3); j++) begin
                    if (base + j < DEPTH) begin
                        put_point(base + j, bx + j * 30000, by - j * 20000);
                        sent++;
                    end
                end
                for (int j = 0; j < $urandom_range(1, 3); j++) begin
                    if (cur_slot < DEPTH && wp_written[cur_slot]) begin
                        bx = longint'($signed(wp_x[cur_slot]));
                        by = longint'($signed(wp_y[cur_slot]));
                    end
                    ask(cur_slot + $urandom_range(0, 4),
                        bx + $signed($urandom_range(0, 40000)) - 20000,
                        by + $signed($urandom_range(0, 40000)) - 20000,
                        $signed($urandom_range(0, 823550)) - 411775,
                        $signed($urandom_range(0, 200000)) - 100000,
                        $signed($urandom_range(0, 200000)) - 100000);
                    sent++;
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_cmd exp_cmd;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cmd_q.size() == 0) begin
                $display("%0t: unexpected command word speed=%0d turn=%0d slot=%0d done=%0d",
                         $time, o_cmd_speed, o_cmd_turn_rate, o_target_slot, o_path_done);
                errors++;
            end else begin
                exp_cmd = cmd_q.pop_front();
                if (o_cmd_speed !== exp_cmd.speed) begin
                    $display("%0t: cmd_speed expected %0d actual %0d",
                             $time, exp_cmd.speed, o_cmd_speed);
                    errors++;
                end
                if (o_cmd_turn_rate !== exp_cmd.turn) begin
                    $display("%0t: cmd_turn_rate expected %0d actual %0d",
                             $time, exp_cmd.turn, o_cmd_turn_rate);
                    errors++;
                end
                if (o_target_slot !== exp_cmd.slot) begin
                    $display("%0t: target_slot expected %0d actual %0d",
                             $time, exp_cmd.slot, o_target_slot);
                    errors++;
                end
                if (o_path_done !== exp_cmd.done) begin
                    $display("%0t: path_done expected %0d actual %0d",
                             $time, exp_cmd.done, o_path_done);
                    errors++;
                end
            end
        end
        i_stall <= gaps_on && ($urandom_range(99) < 6);
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_empty_window();
        test_zero_resolution();
        test_fine_sweep();
        test_past_end();
        set_config(-65536, 131072, 20000, 100000, 30000, 15000, 25000, $urandom_range(0, 1024));
        test_random_phase(28, 1'b1);
        set_config(-200000, 300000, 50000, 200000, 60000, 40000, 50000, $urandom_range(0, 65535));
        test_random_phase(28, 1'b0);
        set_config(0, 65536, 3277, 65536, 6554, 4000, 7000, 256);
        test_random_phase(28, 1'b1);
        drain();
        repeat (50) @(posedge i_clk);
        if (cmd_q.size() == 0 && errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/dwvp_pkg.sv
rtl/dwvp_front.sv
rtl/dwvp_back.sv
rtl/dynamic_window_velocity_planner_top.sv
dv/testbench.sv
